// File: rtl/hntl_pkg.sv
package hntl_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int MAX_NAME_LEN = 12;
    localparam int START_WEIGHT = 3;
    localparam int WEIGHT_W     = $clog2(START_WEIGHT + MAX_NAME_LEN + 1);
    localparam int SUM_W        = 24;
    localparam int KEY_W        = 32;
    localparam int DATA_W       = 32;
    localparam int CHAR_W       = 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CHAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_CACHE,
        ST_PROBE,
        ST_CMP,
        ST_FETCH,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic accept;
        logic make_key;
        logic take_cache;
        logic search_init;
        logic probe;
        logic take_mid;
        logic narrow;
        logic fetch;
        logic resp_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last_char;
        logic cache_hit;
        logic range_empty;
        logic cmp_eq;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/hntl_ctrl.sv
module hntl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  hntl_pkg::t_dp_status i_status,
    output hntl_pkg::t_dp_cmd   o_cmd,
    output logic                o_in_stall
);
    import hntl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.last_char) begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                n_state = ST_CACHE;
            end
            ST_CACHE: begin
                n_state = i_status.cache_hit ? ST_FETCH : ST_PROBE;
            end
            ST_PROBE: begin
                n_state = i_status.range_empty ? ST_RESP : ST_CMP;
            end
            ST_CMP: begin
                n_state = i_status.cmp_eq ? ST_FETCH : ST_PROBE;
            end
            ST_FETCH: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
            end
            ST_KEY: begin
                o_cmd.make_key = 1'b1;
            end
            ST_CACHE: begin
                o_cmd.take_cache  = i_status.cache_hit;
                o_cmd.search_init = !i_status.cache_hit;
            end
            ST_PROBE: begin
                o_cmd.probe = !i_status.range_empty;
            end
            ST_CMP: begin
                o_cmd.take_mid = i_status.cmp_eq;
                o_cmd.narrow   = !i_status.cmp_eq;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            ST_RESP: begin
                o_cmd.resp_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// File: rtl/hntl_dp.sv
module hntl_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hntl_pkg::t_dp_cmd            i_cmd,
    output hntl_pkg::t_dp_status         o_status,
    input  logic                         i_cfg_valid,
    input  logic [hntl_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_req_type,
    input  logic [7:0]                   i_load_index,
    input  logic [hntl_pkg::KEY_W-1:0]   i_load_key,
    input  logic [hntl_pkg::DATA_W-1:0]  i_load_offset,
    input  logic [hntl_pkg::DATA_W-1:0]  i_load_size,
    input  logic signed [7:0]            i_name_char,
    input  logic                         i_name_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [hntl_pkg::DATA_W-1:0]  o_hit_offset,
    output logic [hntl_pkg::DATA_W-1:0]  o_hit_size,
    output logic [hntl_pkg::KEY_W-1:0]   o_name_key
);
    import hntl_pkg::*;

    logic [KEY_W-1:0]  key_mem    [TABLE_DEPTH];
    logic [DATA_W-1:0] offset_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] size_mem   [TABLE_DEPTH];

    logic [CNT_W-1:0]    r_entries;
    logic [SUM_W-1:0]    r_odd;
    logic [SUM_W-1:0]    r_even;
    logic [WEIGHT_W-1:0] r_weight;
    logic [CHAR_W-1:0]   r_first;
    logic [CHAR_W-1:0]   r_top;
    logic                r_cache_valid;
    logic [IDX_W-1:0]    r_cache_slot;
    logic                r_out_valid;

    logic [KEY_W-1:0]    r_key;
    logic [KEY_W-1:0]    r_key_rd;
    logic [DATA_W-1:0]   r_off_rd;
    logic [DATA_W-1:0]   r_size_rd;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [IDX_W-1:0]    r_mid;
    logic [IDX_W-1:0]    r_slot;
    logic                r_hit;
    logic                r_found;
    logic [DATA_W-1:0]   r_hit_offset;
    logic [DATA_W-1:0]   r_hit_size;
    logic [KEY_W-1:0]    r_name_key;

    logic [WEIGHT_W-1:0]  w_count;
    logic signed [12:0]   w_prod;
    logic [SUM_W-1:0]     w_prod_ext;
    logic [SUM_W-1:0]     w_key_prod;
    logic [CNT_W-1:0]     w_mid;
    logic [IDX_W-1:0]     w_key_raddr;
    logic                 w_load;
    logic                 w_char;

    assign w_load = i_cmd.accept && (i_req_type == REQ_LOAD);
    assign w_char = i_cmd.accept && (i_req_type == REQ_CHAR);

    assign w_count    = r_weight - WEIGHT_W'(START_WEIGHT);
    assign w_prod     = 13'($signed({1'b0, r_weight})) * 13'(i_name_char);
    assign w_prod_ext = {{(SUM_W - 13){w_prod[12]}}, w_prod};
    // only the low bits of the key product are kept
    assign w_key_prod = r_odd * r_even;

    assign w_mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign w_key_raddr = i_cmd.probe ? w_mid[IDX_W-1:0] : r_cache_slot;

    assign o_status.last_char   = (i_req_type == REQ_CHAR) && i_name_last;
    assign o_status.cache_hit   = r_cache_valid && (r_key_rd == r_key);
    assign o_status.range_empty = !(r_lo < r_hi);
    assign o_status.cmp_eq      = (r_key_rd == r_key);
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    // table memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            key_mem[i_load_index[IDX_W-1:0]]    <= i_load_key;
            offset_mem[i_load_index[IDX_W-1:0]] <= i_load_offset;
            size_mem[i_load_index[IDX_W-1:0]]   <= i_load_size;
        end
        if (i_cmd.make_key || i_cmd.probe) begin
            r_key_rd <= key_mem[w_key_raddr];
        end
        if (i_cmd.fetch) begin
            r_off_rd  <= offset_mem[r_slot];
            r_size_rd <= size_mem[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries     <= '0;
            r_odd         <= '0;
            r_even        <= '0;
            r_weight      <= WEIGHT_W'(START_WEIGHT);
            r_first       <= '0;
            r_top         <= '0;
            r_cache_valid <= 1'b0;
            r_cache_slot  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entries <= i_cfg_data;
            end
            if (w_load) begin
                r_cache_valid <= 1'b0;
            end
            if (w_char) begin
                if (w_count == '0) begin
                    r_first <= i_name_char;
                    r_top   <= i_name_char;
                end else if (w_count == WEIGHT_W'(1)) begin
                    r_top <= r_first ^ i_name_char;
                end
                // characters past the name limit add nothing
                if (w_count < WEIGHT_W'(MAX_NAME_LEN)) begin
                    if (r_weight[0]) begin
                        r_odd <= r_odd + w_prod_ext;
                    end else begin
                        r_even <= r_even + w_prod_ext;
                    end
                    r_weight <= r_weight + WEIGHT_W'(1);
                end
            end
            if (i_cmd.make_key) begin
                r_odd    <= '0;
                r_even   <= '0;
                r_weight <= WEIGHT_W'(START_WEIGHT);
                r_first  <= '0;
                r_top    <= '0;
            end
            if (i_cmd.resp_load) begin
                r_cache_valid <= r_hit;
                if (r_hit) begin
                    r_cache_slot <= r_slot;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.make_key) begin
            r_key <= {r_top, w_key_prod};
            r_hit <= 1'b0;
        end
        if (i_cmd.take_cache) begin
            r_slot <= r_cache_slot;
            r_hit  <= 1'b1;
        end
        if (i_cmd.search_init) begin
            r_lo <= '0;
            r_hi <= (r_entries > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : r_entries;
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid[IDX_W-1:0];
        end
        if (i_cmd.take_mid) begin
            r_slot <= r_mid;
            r_hit  <= 1'b1;
        end
        // halve the range on signed key order
        if (i_cmd.narrow) begin
            if ($signed(r_key) < $signed(r_key_rd)) begin
                r_hi <= {1'b0, r_mid};
            end else begin
                r_lo <= {1'b0, r_mid} + CNT_W'(1);
            end
        end
        if (i_cmd.resp_load) begin
            r_found      <= r_hit;
            r_hit_offset <= r_hit ? r_off_rd : '0;
            r_hit_size   <= r_hit ? r_size_rd : '0;
            r_name_key   <= r_key;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_hit_offset = r_hit_offset;
    assign o_hit_size   = r_hit_size;
    assign o_name_key   = r_name_key;

endmodule

// File: rtl/hashed_name_table_lookup_core.sv
// Name-hash table lookup. A load transaction writes one table entry (key, offset, size)
// and invalidates the lookup cache; keys must be kept sorted by signed value
// and entries_in_use written through the config port while the block is idle. The last
// name character adds the key multiply and a cache check, then, on a cache miss, a binary
// search in which each probe passes through a probe and a compare state because the key
// memory has one registered read port: up to nine probes for 256 entries. The block takes
// no further transaction until a lookup has loaded its result. The result sits in an output
// register, so loads and characters of the next name proceed while it waits to be taken.
module hashed_name_table_lookup_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hntl_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [7:0]                   i_load_index,
    input  logic [31:0]                  i_load_key,
    input  logic [31:0]                  i_load_offset,
    input  logic [31:0]                  i_load_size,
    input  logic signed [7:0]            i_name_char,
    input  logic                         i_name_last,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_found,
    output logic [31:0]                  o_hit_offset,
    output logic [31:0]                  o_hit_size,
    output logic [31:0]                  o_name_key
);
    import hntl_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    hntl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    hntl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_load_index  (i_load_index),
        .i_load_key    (i_load_key),
        .i_load_offset (i_load_offset),
        .i_load_size   (i_load_size),
        .i_name_char   (i_name_char),
        .i_name_last   (i_name_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_hit_offset  (o_hit_offset),
        .o_hit_size    (o_hit_size),
        .o_name_key    (o_name_key)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command issued");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_hit_offset == '0 && o_hit_size == '0))
        else $error("miss result carries nonzero offset or size");

    a_resp_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.resp_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> !o_in_stall)
        else $error("transaction taken while stalled");

endmodule

// File: tb/sv/hntl_lookup_scoreboard.sv
`timescale 1ns / 100ps

package hntl_lookup_sb_pkg;

    import hntl_pkg::*;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic [31:0] size;
        logic [31:0] key;
    } t_lookup;

    class lookup_scoreboard;

        logic [31:0] key_tab[TABLE_DEPTH];
        logic [31:0] off_tab[TABLE_DEPTH];
        logic [31:0] size_tab[TABLE_DEPTH];
        bit          cache_ok;
        int unsigned cache_idx;
        logic [23:0] odd_acc;
        logic [23:0] even_acc;
        int unsigned wgt;
        logic [7:0]  first_ch;
        logic [7:0]  top_ch;
        int unsigned entries;
        t_lookup     pending_lookups[$];
        int          errors;

        function new();
            cache_ok  = 1'b0;
            cache_idx = 0;
            entries   = 0;
            errors    = 0;
            clear_name();
        endfunction

        function void clear_name();
            odd_acc  = '0;
            even_acc = '0;
            wgt      = START_WEIGHT;
            first_ch = '0;
            top_ch   = '0;
        endfunction

        function void set_entries(int unsigned value);
            entries = value;
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction

        // binary search over [lo, hi); the first probe with an equal key wins
        function bit find_slot(logic [31:0] k, output int unsigned slot);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo   = 0;
            hi   = (entries > TABLE_DEPTH) ? TABLE_DEPTH : entries;
            slot = 0;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (key_tab[mid] == k) begin
                    slot = mid;
                    return 1'b1;
                end
                if ($signed(k) < $signed(key_tab[mid]))
                    hi = mid;
                else
                    lo = mid + 1;
            end
            return 1'b0;
        endfunction

        function void note_transaction(logic req, logic [7:0] idx, logic [31:0] k,
                                       logic [31:0] off, logic [31:0] sz,
                                       logic [7:0] ch, logic last);
            int unsigned pos;
            int unsigned slot;
            logic [31:0] prod;
            logic [47:0] mix;
            t_lookup     res;
            if (req == REQ_LOAD) begin
                key_tab[idx]  = k;
                off_tab[idx]  = off;
                size_tab[idx] = sz;
                cache_ok      = 1'b0;
                return;
            end
            pos = wgt - START_WEIGHT;
            if (pos == 0) begin
                first_ch = ch;
                top_ch   = ch;
            end else if (pos == 1) begin
                top_ch = first_ch ^ ch;
            end
            // characters past the length limit add nothing
            if (pos < MAX_NAME_LEN) begin
                prod = wgt * {{24{ch[7]}}, ch};
                if (wgt % 2 == 1)
                    odd_acc = odd_acc + prod[23:0];
                else
                    even_acc = even_acc + prod[23:0];
                wgt = wgt + 1;
            end
            if (!last)
                return;
            mix       = odd_acc * even_acc;
            res.key   = {top_ch, mix[23:0]};
            res.found = 1'b0;
            slot      = 0;
            if (cache_ok && key_tab[cache_idx] == res.key) begin
                res.found = 1'b1;
                slot      = cache_idx;
            end else begin
                res.found = find_slot(res.key, slot);
            end
            cache_ok = res.found;
            if (res.found)
                cache_idx = slot;
            res.offset = res.found ? off_tab[slot] : 32'h0;
            res.size   = res.found ? size_tab[slot] : 32'h0;
            pending_lookups.push_back(res);
            clear_name();
        endfunction

        function void check_lookup(logic f, logic [31:0] off, logic [31:0] sz,
                                   logic [31:0] k);
            t_lookup want;
            if (pending_lookups.size() == 0) begin
                $error("unrequested lookup result, name_key %h", k);
                errors++;
                return;
            end
            want = pending_lookups.pop_front();
            if (f !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, f);
                errors++;
            end
            if (off !== want.offset) begin
                $error("hit_offset: expected %h, got %h", want.offset, off);
                errors++;
            end
            if (sz !== want.size) begin
                $error("hit_size: expected %h, got %h", want.size, sz);
                errors++;
            end
            if (k !== want.key) begin
                $error("name_key: expected %h, got %h", want.key, k);
                errors++;
            end
        endfunction

    endclass

endpackage

// File: tb/sv/hashed_name_table_lookup_core_test.sv
`timescale 1ns / 100ps

module hashed_name_table_lookup_core_test;

    import hntl_pkg::*;
    import hntl_lookup_sb_pkg::*;

    localparam int POOL_N      = 24;
    localparam int MAX_CHARS   = 20;
    localparam int DRAIN       = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CNT_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               req_type = REQ_LOAD;
    logic [7:0]         load_index = '0;
    logic [31:0]        load_key = '0;
    logic [31:0]        load_offset = '0;
    logic [31:0]        load_size = '0;
    logic [7:0]         name_char = '0;
    logic               name_last = 1'b0;
    logic               out_stall = 1'b0;

    logic               o_cfg_ready;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_found;
    logic [31:0]        o_hit_offset;
    logic [31:0]        o_hit_size;
    logic [31:0]        o_name_key;

    lookup_scoreboard   sb;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int unsigned        cycle_count = 0;

    logic [7:0]         pool_ch[POOL_N][MAX_CHARS];
    int                 pool_len[POOL_N];
    logic [7:0]         cur_name[MAX_CHARS];
    int                 cur_len = 0;
    logic [31:0]        tab_key[TABLE_DEPTH];

    hashed_name_table_lookup_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (req_type),
        .i_load_index  (load_index),
        .i_load_key    (load_key),
        .i_load_offset (load_offset),
        .i_load_size   (load_size),
        .i_name_char   (name_char),
        .i_name_last   (name_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_found       (o_found),
        .o_hit_offset  (o_hit_offset),
        .o_hit_size    (o_hit_size),
        .o_name_key    (o_name_key)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall)
            sb.note_transaction(req_type, load_index, load_key, load_offset, load_size,
                                name_char, name_last);
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_lookup(o_found, o_hit_offset, o_hit_size, o_name_key);
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // key of a pool name, used to seed the table with keys that will hit
    function automatic logic [31:0] pool_key(int p);
        logic [23:0] odd_s;
        logic [23:0] even_s;
        logic [31:0] prod;
        logic [47:0] mix;
        logic [7:0]  top;
        int unsigned w;
        odd_s  = '0;
        even_s = '0;
        w      = START_WEIGHT;
        top    = (pool_len[p] == 1) ? pool_ch[p][0] : pool_ch[p][0] ^ pool_ch[p][1];
        for (int i = 0; i < pool_len[p] && i < MAX_NAME_LEN; i++) begin
            prod = w * {{24{pool_ch[p][i][7]}}, pool_ch[p][i]};
            if (w % 2 == 1)
                odd_s = odd_s + prod[23:0];
            else
                even_s = even_s + prod[23:0];
            w++;
        end
        mix = odd_s * even_s;
        return {top, mix[23:0]};
    endfunction

    task automatic send_transaction(logic req, logic [7:0] idx, logic [31:0] k,
                                    logic [31:0] off, logic [31:0] sz,
                                    logic [7:0] ch, logic last);
        // drop in_valid at random before a transaction, at the sender's idle rate
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        load_index  <= idx;
        load_key    <= k;
        load_offset <= off;
        load_size   <= sz;
        name_char   <= ch;
        name_last   <= last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_load(logic [7:0] idx, logic [31:0] k, logic [31:0] off,
                             logic [31:0] sz);
        send_transaction(REQ_LOAD, idx, k, off, sz, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_char(logic [7:0] ch, logic last);
        send_transaction(REQ_CHAR, 8'($urandom), $urandom, $urandom, $urandom, ch, last);
    endtask

    // rewrite offset and size under the same key, so the table stays sorted
    task automatic send_rewrite();
        int unsigned idx;
        idx = $urandom_range(TABLE_DEPTH - 1);
        send_load(8'(idx), tab_key[idx], rand_word(), rand_word());
    endtask

    // send cur_name, now and then slipping a table load between characters
    task automatic send_name(output int items);
        items = 0;
        for (int i = 0; i < cur_len; i++) begin
            if (i > 0 && $urandom_range(99) < 8) begin
                send_rewrite();
                items++;
            end
            send_char(cur_name[i], i == cur_len - 1);
            items++;
        end
    endtask

    task automatic write_entries(int unsigned value);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_entries(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_sorted_table();
        int sk[$];
        for (int p = 0; p < POOL_N; p++)
            sk.push_back(int'(pool_key(p)));
        sk.push_back(int'(32'h8000_0000));
        sk.push_back(int'(32'h7fff_ffff));
        while (sk.size() < TABLE_DEPTH)
            sk.push_back(int'($urandom));
        sk.sort();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tab_key[i] = sk[i];
            send_load(8'(i), sk[i], rand_word(), rand_word());
        end
    endtask

    task automatic run_random(int n_items);
        int sent;
        int pick;
        int items;
        int unsigned idx;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_rewrite();
                sent++;
            end else if (pick < 15) begin
                // unsorted key: the search must still follow the same probes
                idx          = $urandom_range(TABLE_DEPTH - 1);
                tab_key[idx] = rand_word();
                send_load(8'(idx), tab_key[idx], rand_word(), rand_word());
                sent++;
            end else begin
                if (pick < 30 && cur_len > 0) begin
                    // repeat the previous name to exercise the cache
                end else if (pick < 75) begin
                    idx     = $urandom_range(POOL_N - 1);
                    cur_len = pool_len[idx];
                    for (int i = 0; i < cur_len; i++)
                        cur_name[i] = pool_ch[idx][i];
                end else begin
                    cur_len = ($urandom_range(4) == 0) ? $urandom_range(13, MAX_CHARS)
                                                       : $urandom_range(1, 12);
                    for (int i = 0; i < cur_len; i++)
                        cur_name[i] = 8'($urandom);
                end
                send_name(items);
                sent += items;
            end
        end
    endtask

    task automatic run_phase(int unsigned entries, int s_pct, int r_pct, int n_items);
        write_entries(entries);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        run_random(n_items);
    endtask

    initial begin
        int items;
        sb = new();
        for (int p = 0; p < POOL_N; p++) begin
            pool_len[p] = (p == 0) ? 1 : (p == 1) ? 2 :
                          (p < 4) ? $urandom_range(13, MAX_CHARS) : $urandom_range(1, 12);
            for (int i = 0; i < MAX_CHARS; i++)
                pool_ch[p][i] = 8'($urandom_range(1, 255));
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 34;
        recv_idle_pct = 53;
        write_entries(0);

        // empty table: every lookup misses without probing an entry
        send_load(8'd255, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_load(8'd0, 32'h0, 32'h0, 32'h0);
        send_char(8'h80, 1'b1);
        send_char(8'h7f, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b1);
        // past the length limit, the last flag still ends the name
        cur_len = 15;
        for (int i = 0; i < cur_len; i++)
            cur_name[i] = (i % 3 == 0) ? 8'h7f : (i % 3 == 1) ? 8'h80 : 8'h00;
        send_name(items);

        load_sorted_table();

        run_phase(256, 34, 53, 36);
        run_phase(511, 34, 53, 36);
        run_phase(1, 53, 34, 36);
        run_phase($urandom_range(2, 255), 53, 34, 36);
        run_phase(256, 0, 0, 36);
        run_phase($urandom_range(2, 200), 0, 0, 36);

        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
